// File: src/http_request_uri_tokenizer_top_macros.svh
// ----------------------------------------------------------------------------
// HTTP request-URI tokenizer assertion macros
// Concurrent assertion wrappers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_URI_TOKENIZER_TOP_MACROS_SVH
`define HTTP_REQUEST_URI_TOKENIZER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge outside reset.
`define HRUT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("hrut assertion failed");

// A condition that must be followed by a consequence in the next cycle.
`define HRUT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hrut assertion failed");

`else

`define HRUT_ASSERT(lbl, clk, rst_n, prop)
`define HRUT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: src/hrut_pkg.sv
// ----------------------------------------------------------------------------
// HTTP request-URI tokenizer package
// Shared codes, character constants, types and the scheme lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package hrut_pkg;

  // Width of the field capacity register and its reset value.
  localparam int unsigned CfgW = 13;
  localparam logic [CfgW-1:0] CapacityReset = 13'd1024;

  // Default upper bound on the per-field byte count.
  localparam int unsigned MaxFieldBytesDef = 4096;

  // Characters with a special meaning in the grammar.
  localparam logic [7:0] ChSp    = " ";
  localparam logic [7:0] ChHt    = 8'h09;
  localparam logic [7:0] ChStar  = "*";
  localparam logic [7:0] ChSlash = "/";
  localparam logic [7:0] ChColon = ":";
  localparam logic [7:0] ChQmark = "?";
  localparam logic [7:0] ChHash  = "#";
  localparam logic [7:0] ChPlus  = "+";
  localparam logic [7:0] ChMinus = "-";
  localparam logic [7:0] ChDot   = ".";
  localparam logic [7:0] ChSemi  = ";";

  // Scheme match progress: characters of "https" matched so far.
  localparam logic [2:0] MatchHttp  = 3'd4;
  localparam logic [2:0] MatchHttps = 3'd5;
  localparam logic [2:0] MatchNone  = 3'd7;

  typedef enum logic [3:0] {
    ROLE_NONE     = 4'd0,
    ROLE_SCHEME   = 4'd1,
    ROLE_HOST     = 4'd2,
    ROLE_PORT     = 4'd3,
    ROLE_PATH     = 4'd4,
    ROLE_QUERY    = 4'd5,
    ROLE_FRAG     = 4'd6,
    ROLE_OPAQUE   = 4'd7,
    ROLE_ASTERISK = 4'd8
  } role_e;

  typedef enum logic [3:0] {
    ERR_NONE     = 4'd0,
    ERR_ASTERISK = 4'd1,
    ERR_SCHEME   = 4'd2,
    ERR_HOST     = 4'd3,
    ERR_PORT     = 4'd4,
    ERR_PATH     = 4'd5,
    ERR_QUERY    = 4'd6,
    ERR_FRAG     = 4'd7,
    ERR_OVERFLOW = 4'd8,
    ERR_AFTER    = 4'd9
  } error_e;

  typedef enum logic [2:0] {
    KIND_UNKNOWN  = 3'd0,
    KIND_ASTERISK = 3'd1,
    KIND_HTTP     = 3'd2,
    KIND_HTTPS    = 3'd3,
    KIND_OTHER    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_BUSY  = 2'd0,
    STATUS_DONE  = 2'd1,
    STATUS_ERROR = 2'd2
  } status_e;

  typedef enum logic [12:0] {
    PH_SKIP   = 13'b0_0000_0000_0001,
    PH_AST    = 13'b0_0000_0000_0010,
    PH_AST_SP = 13'b0_0000_0000_0100,
    PH_SCHEME = 13'b0_0000_0000_1000,
    PH_SLASH  = 13'b0_0000_0001_0000,
    PH_HOST   = 13'b0_0000_0010_0000,
    PH_PORT   = 13'b0_0000_0100_0000,
    PH_PATH   = 13'b0_0000_1000_0000,
    PH_QUERY  = 13'b0_0001_0000_0000,
    PH_FRAG   = 13'b0_0010_0000_0000,
    PH_OPAQUE = 13'b0_0100_0000_0000,
    PH_DONE   = 13'b0_1000_0000_0000,
    PH_ERR    = 13'b1_0000_0000_0000
  } phase_e;

  // Character classes of one byte.
  typedef struct packed {
    logic sp;
    logic alpha;
    logic digit;
    logic alnum;
    logic pchar;
    logic uric;
  } hrut_class_t;

  // One result beat as produced by the parser core.
  typedef struct packed {
    role_e       byte_role;
    logic [7:0]  echo_byte;
    status_e     parse_status;
    error_e      error_code;
    kind_e       uri_kind;
    logic [15:0] port_value;
    logic        port_given;
    logic        default_path;
  } hrut_result_t;

  // Expected character of "https" at a given match position.
  function automatic logic [7:0] https_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = "h";
      3'd1:    ch = "t";
      3'd2:    ch = "t";
      3'd3:    ch = "p";
      3'd4:    ch = "s";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: src/hrut_in_if.sv
// ----------------------------------------------------------------------------
// HTTP request-URI tokenizer input channel
// Valid/ready channel carrying one URI byte or a restart command per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrut_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] octet;

  modport source (output valid, action, octet, input ready);
  modport sink   (input valid, action, octet, output ready);
endinterface

`default_nettype wire

// File: src/hrut_out_if.sv
// ----------------------------------------------------------------------------
// HTTP request-URI tokenizer output channel
// Valid/ready channel carrying the role and parse status of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface hrut_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  byte_role;
  logic [7:0]  echo_byte;
  logic [1:0]  parse_status;
  logic [3:0]  error_code;
  logic [2:0]  uri_kind;
  logic [15:0] port_value;
  logic        port_given;
  logic        default_path;

  modport source (
    output valid, byte_role, echo_byte, parse_status, error_code, uri_kind,
           port_value, port_given, default_path,
    input  ready
  );
  modport sink (
    input  valid, byte_role, echo_byte, parse_status, error_code, uri_kind,
           port_value, port_given, default_path,
    output ready
  );
endinterface

`default_nettype wire

// File: src/hrut_char_class.sv
// ----------------------------------------------------------------------------
// HTTP request-URI tokenizer character classifier
// Decodes one byte into the URI character classes used by the parser.
// ----------------------------------------------------------------------------
`default_nettype none

module hrut_char_class (
  input  wire logic [7:0]          octet_i,
  output hrut_pkg::hrut_class_t    class_o
);
  import hrut_pkg::*;

  logic alpha;
  logic digit;
  logic mark;
  logic unreserved;
  logic pchar;

  assign alpha = (octet_i >= "a" && octet_i <= "z") || (octet_i >= "A" && octet_i <= "Z");
  assign digit = (octet_i >= "0" && octet_i <= "9");

  assign mark = (octet_i == "-") || (octet_i == "_") || (octet_i == ".") ||
                (octet_i == "!") || (octet_i == "~") || (octet_i == "*") ||
                (octet_i == "'") || (octet_i == "(") || (octet_i == ")");

  // Percent signs pass through undecoded as ordinary text.
  assign unreserved = alpha || digit || mark || (octet_i == "%");

  assign pchar = unreserved || (octet_i == ":") || (octet_i == "@") ||
                 (octet_i == "&") || (octet_i == "=") || (octet_i == "+") ||
                 (octet_i == "$") || (octet_i == ",");

  assign class_o.sp    = (octet_i == ChSp) || (octet_i == ChHt);
  assign class_o.alpha = alpha;
  assign class_o.digit = digit;
  assign class_o.alnum = alpha || digit;
  assign class_o.pchar = pchar;
  assign class_o.uric  = pchar || (octet_i == ChSemi) || (octet_i == ChSlash) ||
                         (octet_i == ChQmark);

endmodule

`default_nettype wire

// File: src/hrut_parse_core.sv
// ----------------------------------------------------------------------------
// HTTP request-URI tokenizer parser core
// Holds the parse state and computes the role and status of one byte.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_request_uri_tokenizer_top_macros.svh"

module hrut_parse_core #(
  parameter int unsigned MAX_FIELD_BYTES = hrut_pkg::MaxFieldBytesDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [hrut_pkg::CfgW-1:0] capacity_i,
  input  wire logic                      step_i,
  input  wire logic                      action_i,
  input  wire logic [7:0]                octet_i,
  output hrut_pkg::hrut_result_t         result_o
);
  import hrut_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_FIELD_BYTES + 1);
  localparam int unsigned CmpW = (CntW > CfgW) ? CntW : CfgW;

  hrut_class_t cls;

  phase_e           phase_q, phase_d, eff_phase;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [2:0]       match_q, match_d, match_take;
  logic [15:0]      port_q, port_d;
  logic             seen_q, seen_d;
  kind_e            kind_q, kind_d;
  error_e           err_q, err_d;
  logic             dflt_q, dflt_d;

  role_e            role;
  logic             fail;
  error_e           fail_code;

  logic [CmpW-1:0]  cap_ext, cap_lim, cap_eff;
  logic             room;
  logic             room0;
  logic [19:0]      port_acc_ext, port_next;
  logic             port_ovf;

  hrut_char_class u_class (
    .octet_i (octet_i),
    .class_o (cls)
  );

  // Capacity above the build limit acts as the limit.
  assign cap_ext = CmpW'(capacity_i);
  assign cap_lim = CmpW'(MAX_FIELD_BYTES);
  assign cap_eff = (cap_ext > cap_lim) ? cap_lim : cap_ext;
  assign room    = CmpW'(cnt_q) < cap_eff;
  assign room0   = (cap_eff != '0);

  // Next port value: times ten as two shifts, digit value is the low nibble.
  assign port_acc_ext = 20'(port_q);
  assign port_next    = (port_acc_ext << 3) + (port_acc_ext << 1) + 20'(octet_i[3:0]);
  assign port_ovf     = |port_next[19:16];

  assign match_take = ((match_q < MatchHttps) && (octet_i == https_char(match_q))) ?
                      match_q + 3'd1 : MatchNone;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    match_d   = match_q;
    port_d    = port_q;
    seen_d    = seen_q;
    kind_d    = kind_q;
    err_d     = err_q;
    dflt_d    = dflt_q;
    role      = ROLE_NONE;
    fail      = 1'b0;
    fail_code = ERR_NONE;
    eff_phase = phase_q;

    if (step_i) begin
      if (action_i) begin
        phase_d = PH_SKIP;
        cnt_d   = '0;
        match_d = 3'd0;
        port_d  = '0;
        seen_d  = 1'b0;
        kind_d  = KIND_UNKNOWN;
        err_d   = ERR_NONE;
        dflt_d  = 1'b0;
      end else if (err_q == ERR_NONE) begin
        // The first significant byte and the first byte after the slashes are
        // handled by the phase they lead into.
        if (phase_q == PH_SKIP && !cls.sp) begin
          eff_phase = (octet_i == ChStar)  ? PH_AST :
                      (octet_i == ChSlash) ? PH_PATH : PH_SCHEME;
        end else if (phase_q == PH_SLASH && octet_i != ChSlash) begin
          eff_phase = PH_HOST;
        end
        phase_d = eff_phase;

        case (eff_phase)
          PH_AST: begin
            if (octet_i != ChStar) begin
              fail = 1'b1; fail_code = ERR_ASTERISK;
            end else begin
              phase_d = PH_AST_SP;
              role    = ROLE_ASTERISK;
            end
          end
          PH_AST_SP: begin
            if (!cls.sp) begin
              fail = 1'b1; fail_code = ERR_ASTERISK;
            end else begin
              kind_d  = KIND_ASTERISK;
              phase_d = PH_DONE;
            end
          end
          PH_SCHEME: begin
            if (!room) begin
              fail = 1'b1; fail_code = ERR_OVERFLOW;
            end else if (cnt_q == '0) begin
              if (!cls.alpha) begin
                fail = 1'b1; fail_code = ERR_SCHEME;
              end else begin
                match_d = match_take;
                cnt_d   = cnt_q + 1'b1;
                role    = ROLE_SCHEME;
              end
            end else if (cls.alnum || octet_i == ChPlus || octet_i == ChMinus ||
                         octet_i == ChDot) begin
              match_d = match_take;
              cnt_d   = cnt_q + 1'b1;
              role    = ROLE_SCHEME;
            end else if (octet_i != ChColon) begin
              fail = 1'b1; fail_code = ERR_SCHEME;
            end else if (match_q == MatchHttp || match_q == MatchHttps) begin
              kind_d  = (match_q == MatchHttp) ? KIND_HTTP : KIND_HTTPS;
              cnt_d   = '0;
              phase_d = PH_SLASH;
            end else begin
              // The colon of any other scheme belongs to the opaque text.
              kind_d  = KIND_OTHER;
              cnt_d   = cnt_q + 1'b1;
              phase_d = PH_OPAQUE;
              role    = ROLE_OPAQUE;
            end
          end
          PH_HOST: begin
            if (!room) begin
              fail = 1'b1; fail_code = ERR_OVERFLOW;
            end else if (cnt_q == '0) begin
              if (!cls.alnum) begin
                fail = 1'b1; fail_code = ERR_HOST;
              end else begin
                cnt_d = cnt_q + 1'b1;
                role  = ROLE_HOST;
              end
            end else if (cls.alnum || octet_i == ChMinus || octet_i == ChDot) begin
              cnt_d = cnt_q + 1'b1;
              role  = ROLE_HOST;
            end else begin
              cnt_d = '0;
              if (octet_i == ChColon) begin
                phase_d = PH_PORT;
              end else if (octet_i == ChSlash) begin
                // The slash opens the path and is its first byte.
                if (!room0) begin
                  fail = 1'b1; fail_code = ERR_OVERFLOW;
                end else begin
                  cnt_d   = CntW'(1);
                  phase_d = PH_PATH;
                  role    = ROLE_PATH;
                end
              end else if (cls.sp) begin
                dflt_d = 1'b1; phase_d = PH_DONE;
              end else if (octet_i == ChQmark) begin
                dflt_d = 1'b1; phase_d = PH_QUERY;
              end else if (octet_i == ChHash) begin
                dflt_d = 1'b1; phase_d = PH_FRAG;
              end else begin
                fail = 1'b1; fail_code = ERR_HOST;
              end
            end
          end
          PH_PORT: begin
            if (cls.digit) begin
              if (port_ovf) begin
                fail = 1'b1; fail_code = ERR_PORT;
              end else begin
                port_d = port_next[15:0];
                seen_d = 1'b1;
                role   = ROLE_PORT;
              end
            end else if (!seen_q) begin
              fail = 1'b1; fail_code = ERR_PORT;
            end else begin
              cnt_d = '0;
              if (octet_i == ChSlash) begin
                if (!room0) begin
                  fail = 1'b1; fail_code = ERR_OVERFLOW;
                end else begin
                  cnt_d   = CntW'(1);
                  phase_d = PH_PATH;
                  role    = ROLE_PATH;
                end
              end else if (cls.sp) begin
                dflt_d = 1'b1; phase_d = PH_DONE;
              end else if (octet_i == ChQmark) begin
                dflt_d = 1'b1; phase_d = PH_QUERY;
              end else if (octet_i == ChHash) begin
                dflt_d = 1'b1; phase_d = PH_FRAG;
              end else begin
                fail = 1'b1; fail_code = ERR_PORT;
              end
            end
          end
          PH_PATH: begin
            if (!room) begin
              fail = 1'b1; fail_code = ERR_OVERFLOW;
            end else if (cnt_q == '0) begin
              if (octet_i != ChSlash) begin
                fail = 1'b1; fail_code = ERR_PATH;
              end else begin
                cnt_d = cnt_q + 1'b1;
                role  = ROLE_PATH;
              end
            end else if (cls.pchar || octet_i == ChSlash || octet_i == ChSemi) begin
              cnt_d = cnt_q + 1'b1;
              role  = ROLE_PATH;
            end else begin
              cnt_d = '0;
              if (octet_i == ChQmark) begin
                phase_d = PH_QUERY;
              end else if (octet_i == ChHash) begin
                phase_d = PH_FRAG;
              end else if (cls.sp) begin
                phase_d = PH_DONE;
              end else begin
                fail = 1'b1; fail_code = ERR_PATH;
              end
            end
          end
          PH_QUERY: begin
            if (!room) begin
              fail = 1'b1; fail_code = ERR_OVERFLOW;
            end else if (cls.uric) begin
              cnt_d = cnt_q + 1'b1;
              role  = ROLE_QUERY;
            end else begin
              cnt_d = '0;
              if (octet_i == ChHash) begin
                phase_d = PH_FRAG;
              end else if (cls.sp) begin
                phase_d = PH_DONE;
              end else begin
                fail = 1'b1; fail_code = ERR_QUERY;
              end
            end
          end
          PH_FRAG: begin
            if (!room) begin
              fail = 1'b1; fail_code = ERR_OVERFLOW;
            end else if (cls.uric) begin
              cnt_d = cnt_q + 1'b1;
              role  = ROLE_FRAG;
            end else begin
              cnt_d = '0;
              if (cls.sp) begin
                phase_d = PH_DONE;
              end else begin
                fail = 1'b1; fail_code = ERR_FRAG;
              end
            end
          end
          PH_OPAQUE: begin
            if (!room) begin
              fail = 1'b1; fail_code = ERR_OVERFLOW;
            end else if (cls.sp) begin
              cnt_d   = '0;
              phase_d = PH_DONE;
            end else begin
              cnt_d = cnt_q + 1'b1;
              role  = ROLE_OPAQUE;
            end
          end
          PH_DONE: begin
            fail = 1'b1; fail_code = ERR_AFTER;
          end
          default: begin
            // Leading blanks and the slash run after the scheme are skipped.
          end
        endcase

        if (fail) begin
          err_d   = fail_code;
          phase_d = PH_ERR;
          role    = ROLE_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      cnt_q   <= '0;
      match_q <= 3'd0;
      port_q  <= '0;
      seen_q  <= 1'b0;
      kind_q  <= KIND_UNKNOWN;
      err_q   <= ERR_NONE;
      dflt_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      match_q <= match_d;
      port_q  <= port_d;
      seen_q  <= seen_d;
      kind_q  <= kind_d;
      err_q   <= err_d;
      dflt_q  <= dflt_d;
    end
  end

  // The result reports the state left behind by this byte.
  assign result_o.byte_role    = role;
  assign result_o.echo_byte    = action_i ? 8'h00 : octet_i;
  assign result_o.parse_status = (err_d != ERR_NONE) ? STATUS_ERROR :
                                 (phase_d == PH_DONE) ? STATUS_DONE : STATUS_BUSY;
  assign result_o.error_code   = err_d;
  assign result_o.uri_kind     = kind_d;
  assign result_o.port_value   = port_d;
  assign result_o.port_given   = seen_d;
  assign result_o.default_path = dflt_d;

  `HRUT_ASSERT(a_err_phase, clk_i, rst_ni, (err_q != ERR_NONE) == (phase_q == PH_ERR))
  `HRUT_ASSERT_NEXT(a_err_sticky, clk_i, rst_ni,
    (err_q != ERR_NONE) && !(step_i && action_i), $stable(err_q))
  `HRUT_ASSERT_NEXT(a_port_grows, clk_i, rst_ni,
    step_i && !action_i, port_q >= $past(port_q))
  `HRUT_ASSERT(a_ast_end, clk_i, rst_ni,
    (kind_q != KIND_ASTERISK) || (phase_q == PH_DONE) || (phase_q == PH_ERR))

endmodule

`default_nettype wire

// File: src/http_request_uri_tokenizer_top.sv
// ----------------------------------------------------------------------------
// HTTP request-URI tokenizer top level
// Tags each request-URI byte with its role and reports the parse status.
// ----------------------------------------------------------------------------
// Usage: each beat on byte_in_i carries either one URI byte (action 0) or a
// restart command (action 1) that returns the parser to its initial state
// for a new request. For every input beat exactly one result beat leaves on
// tag_out_o, in order, carrying the byte's role, the byte itself (zero for a
// restart), the parse status, the sticky error code, the URI kind and the
// port parsed so far.
// The beat is captured in an input register, classified and stepped through
// the parser, and captured in the result register. Throughput is one beat
// per cycle while the receiver keeps tag_out_o.ready high; the only loop is
// the parse state, which is updated once per byte.
// When the receiver stalls, the result register holds its beat and the input
// register keeps one more; byte_in_i.ready falls only when both are full.
// Reset clears both registers, the parse state, and sets the field capacity
// to 1024. The capacity is written through cfg_we_i/cfg_wdata_i while the
// block is idle; the user must keep to this, as the block itself does not
// enforce it. Values above MAX_FIELD_BYTES act as MAX_FIELD_BYTES.
// ----------------------------------------------------------------------------
`default_nettype none

module http_request_uri_tokenizer_top #(
  parameter int unsigned MAX_FIELD_BYTES = hrut_pkg::MaxFieldBytesDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [hrut_pkg::CfgW-1:0] cfg_wdata_i,
  hrut_in_if.sink                        byte_in_i,
  hrut_out_if.source                     tag_out_o
);
  import hrut_pkg::*;

  logic [CfgW-1:0] capacity_q;

  // Input register.
  logic            in_vld_q;
  logic            in_action_q;
  logic [7:0]      in_octet_q;

  // Result register.
  logic            out_vld_q;
  hrut_result_t    result_q;
  hrut_result_t    result_d;

  logic            advance;
  logic            in_take;

  // The input beat moves on whenever the result register is free or drained.
  assign advance = in_vld_q && (!out_vld_q || tag_out_o.ready);
  assign byte_in_i.ready = !in_vld_q || advance;
  assign in_take = byte_in_i.valid && byte_in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CapacityReset;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_action_q <= byte_in_i.action;
      in_octet_q  <= byte_in_i.octet;
    end
  end

  hrut_parse_core #(
    .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .capacity_i (capacity_q),
    .step_i     (advance),
    .action_i   (in_action_q),
    .octet_i    (in_octet_q),
    .result_o   (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (tag_out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign tag_out_o.valid        = out_vld_q;
  assign tag_out_o.byte_role    = result_q.byte_role;
  assign tag_out_o.echo_byte    = result_q.echo_byte;
  assign tag_out_o.parse_status = result_q.parse_status;
  assign tag_out_o.error_code   = result_q.error_code;
  assign tag_out_o.uri_kind     = result_q.uri_kind;
  assign tag_out_o.port_value   = result_q.port_value;
  assign tag_out_o.port_given   = result_q.port_given;
  assign tag_out_o.default_path = result_q.default_path;

endmodule

`default_nettype wire

// File: dv/tb_http_request_uri_tokenizer_top.sv
// ----------------------------------------------------------------------------
// HTTP request-URI tokenizer testbench
// Drives request-URI bytes and restarts into the tokenizer under random
// sender gaps and receiver stalls. Every result beat is checked field by
// field, against a hand-written result for some directed beats and otherwise
// against a cycle-free model of the tagger that runs alongside. A short directed
// list of beats comes first, then random requests under a series of field capacity settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_http_request_uri_tokenizer_top;
  import hrut_pkg::*;

  // Run limits. The cycle limit leaves a wide margin over roughly 1200 beats.
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned GapMax     = 8;
  localparam int unsigned PhaseBeats = 92;
  localparam int unsigned DrainHold  = 8;
  localparam int unsigned PortLimit  = 65536;

  // Action codes of an input beat.
  localparam logic ActData    = 1'b0;
  localparam logic ActRestart = 1'b1;

  localparam logic [7:0]  ChDigit0  = "0";
  localparam logic [39:0] HttpsWord = "https";

  // Character pools for building requests.
  localparam string Letters     = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
  localparam string Digits      = "0123456789";
  localparam string Alnum       = {Letters, Digits};
  localparam string HostChars   = {Alnum, "-."};
  localparam string SchemeChars = {Alnum, "+-."};
  localparam string PathChars   = {Alnum, "-_.!~*'()%:@&=+$,/;"};
  localparam string UricChars   = {PathChars, "?"};
  localparam string Blanks      = " \t";

  typedef enum logic [1:0] {
    ROW_DATA,
    ROW_RESTART,
    ROW_CAP
  } row_op_e;

  // One line of the directed list: a data byte, a restart or a capacity write.
  typedef struct {
    row_op_e      op;
    logic [12:0]  value;
    bit           typed;
    hrut_result_t tag;
  } dir_row_t;

  typedef struct {
    logic       act;
    logic [7:0] octet;
  } uri_beat_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_wdata_i;

  hrut_in_if  byte_in ();
  hrut_out_if tag_out ();

  http_request_uri_tokenizer_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_in_i   (byte_in),
    .tag_out_o   (tag_out)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // --------------------------------------------------------------------------
  // Tagger model state. It mirrors the parse state of the block and is
  // stepped once for every accepted input beat.
  // --------------------------------------------------------------------------
  logic [CfgW-1:0] cap_reg;
  phase_e          ph;
  int              fld_cnt;
  logic [2:0]      sch_match;
  int              port_acc;
  bit              port_seen;
  kind_e           kind;
  error_e          err;
  bit              path_dflt;

  hrut_result_t expected_tags [$];
  uri_beat_t    uri_beats [$];
  dir_row_t     dir_rows [$];
  int           mismatch_count;
  int           cycle_count;
  bit           no_idle;
  logic [12:0]  cap_plan [10] = '{13'd1, 13'd3, 13'd8191, 13'd2, 13'd4096,
                                  13'd12, 13'd5, 13'd40, 13'd1024, 13'd7};

  function automatic bit in_set(logic [7:0] c, string s);
    foreach (s[i]) begin
      if (s[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == ChSp || c == ChHt;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alnum_c(logic [7:0] c);
    return is_letter(c) || is_num(c);
  endfunction

  // Path characters per RFC 2396, with '%' passed through undecoded.
  function automatic bit is_pchar_c(logic [7:0] c);
    return is_alnum_c(c) || in_set(c, "-_.!~*'()%:@&=+$,");
  endfunction

  function automatic bit is_uric_c(logic [7:0] c);
    return is_pchar_c(c) || in_set(c, ";/?");
  endfunction

  function automatic bit has_room();
    int lim;
    lim = (int'(cap_reg) > int'(MaxFieldBytesDef)) ? int'(MaxFieldBytesDef) : int'(cap_reg);
    return fld_cnt < lim;
  endfunction

  function automatic void clear_state();
    ph        = PH_SKIP;
    fld_cnt   = 0;
    sch_match = '0;
    port_acc  = 0;
    port_seen = 1'b0;
    kind      = KIND_UNKNOWN;
    err       = ERR_NONE;
    path_dflt = 1'b0;
  endfunction

  function automatic role_e raise(error_e e);
    err = e;
    ph  = PH_ERR;
    return ROLE_NONE;
  endfunction

  // Tracks how far the scheme follows "https"; any other character kills it.
  function automatic void take_scheme(logic [7:0] c);
    if (sch_match < 3'd5 && c == HttpsWord[8*(4-int'(sch_match)) +: 8]) begin
      sch_match = sch_match + 3'd1;
    end else begin
      sch_match = MatchNone;
    end
    fld_cnt++;
  endfunction

  // The end of a host or of a port. Returns 1 when the byte opens the path
  // and must be stepped again in the path phase.
  function automatic bit leave_authority(logic [7:0] c, error_e e);
    role_e dummy;
    if (c == ChSlash) begin
      ph = PH_PATH;
      return 1'b1;
    end
    if (is_blank(c)) begin
      path_dflt = 1'b1;
      ph = PH_DONE;
    end else if (c == ChQmark) begin
      path_dflt = 1'b1;
      ph = PH_QUERY;
    end else if (c == ChHash) begin
      path_dflt = 1'b1;
      ph = PH_FRAG;
    end else begin
      dummy = raise(e);
    end
    return 1'b0;
  endfunction

  // Steps the parse phase by one byte and returns the role of that byte.
  function automatic role_e tag_byte(logic [7:0] c);
    role_e r;
    bit    again;
    int    v;
    r = ROLE_NONE;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (ph)
        PH_SKIP: begin
          if (!is_blank(c)) begin
            ph = (c == ChStar) ? PH_AST : (c == ChSlash) ? PH_PATH : PH_SCHEME;
            again = 1'b1;
          end
        end
        PH_AST: begin
          if (c != ChStar) begin
            r = raise(ERR_ASTERISK);
          end else begin
            ph = PH_AST_SP;
            r = ROLE_ASTERISK;
          end
        end
        PH_AST_SP: begin
          if (!is_blank(c)) begin
            r = raise(ERR_ASTERISK);
          end else begin
            kind = KIND_ASTERISK;
            ph = PH_DONE;
          end
        end
        PH_SCHEME: begin
          if (!has_room()) begin
            r = raise(ERR_OVERFLOW);
          end else if (fld_cnt == 0) begin
            if (!is_letter(c)) begin
              r = raise(ERR_SCHEME);
            end else begin
              take_scheme(c);
              r = ROLE_SCHEME;
            end
          end else if (is_alnum_c(c) || c == ChPlus || c == ChMinus || c == ChDot) begin
            take_scheme(c);
            r = ROLE_SCHEME;
          end else if (c != ChColon) begin
            r = raise(ERR_SCHEME);
          end else if (sch_match == MatchHttp || sch_match == MatchHttps) begin
            kind = (sch_match == MatchHttp) ? KIND_HTTP : KIND_HTTPS;
            fld_cnt = 0;
            ph = PH_SLASH;
          end else begin
            // For any other scheme the colon already belongs to the opaque text.
            kind = KIND_OTHER;
            fld_cnt++;
            ph = PH_OPAQUE;
            r = ROLE_OPAQUE;
          end
        end
        PH_SLASH: begin
          if (c != ChSlash) begin
            ph = PH_HOST;
            again = 1'b1;
          end
        end
        PH_HOST: begin
          if (!has_room()) begin
            r = raise(ERR_OVERFLOW);
          end else if (fld_cnt == 0) begin
            if (!is_alnum_c(c)) begin
              r = raise(ERR_HOST);
            end else begin
              fld_cnt++;
              r = ROLE_HOST;
            end
          end else if (is_alnum_c(c) || c == ChMinus || c == ChDot) begin
            fld_cnt++;
            r = ROLE_HOST;
          end else if (c == ChColon) begin
            fld_cnt = 0;
            ph = PH_PORT;
          end else begin
            fld_cnt = 0;
            again = leave_authority(c, ERR_HOST);
          end
        end
        PH_PORT: begin
          if (is_num(c)) begin
            v = port_acc * 10 + int'(c - ChDigit0);
            if (v >= int'(PortLimit)) begin
              r = raise(ERR_PORT);
            end else begin
              port_acc = v;
              port_seen = 1'b1;
              r = ROLE_PORT;
            end
          end else if (!port_seen) begin
            r = raise(ERR_PORT);
          end else begin
            fld_cnt = 0;
            again = leave_authority(c, ERR_PORT);
          end
        end
        PH_PATH: begin
          if (!has_room()) begin
            r = raise(ERR_OVERFLOW);
          end else if (fld_cnt == 0) begin
            if (c != ChSlash) begin
              r = raise(ERR_PATH);
            end else begin
              fld_cnt++;
              r = ROLE_PATH;
            end
          end else if (is_pchar_c(c) || c == ChSlash || c == ChSemi) begin
            fld_cnt++;
            r = ROLE_PATH;
          end else begin
            fld_cnt = 0;
            if (c == ChQmark) ph = PH_QUERY;
            else if (c == ChHash) ph = PH_FRAG;
            else if (is_blank(c)) ph = PH_DONE;
            else r = raise(ERR_PATH);
          end
        end
        PH_QUERY: begin
          if (!has_room()) begin
            r = raise(ERR_OVERFLOW);
          end else if (is_uric_c(c)) begin
            fld_cnt++;
            r = ROLE_QUERY;
          end else begin
            fld_cnt = 0;
            if (c == ChHash) ph = PH_FRAG;
            else if (is_blank(c)) ph = PH_DONE;
            else r = raise(ERR_QUERY);
          end
        end
        PH_FRAG: begin
          if (!has_room()) begin
            r = raise(ERR_OVERFLOW);
          end else if (is_uric_c(c)) begin
            fld_cnt++;
            r = ROLE_FRAG;
          end else begin
            fld_cnt = 0;
            if (is_blank(c)) ph = PH_DONE;
            else r = raise(ERR_FRAG);
          end
        end
        PH_OPAQUE: begin
          if (!has_room()) begin
            r = raise(ERR_OVERFLOW);
          end else if (is_blank(c)) begin
            fld_cnt = 0;
            ph = PH_DONE;
          end else begin
            fld_cnt++;
            r = ROLE_OPAQUE;
          end
        end
        PH_DONE: r = raise(ERR_AFTER);
        default: r = ROLE_NONE;
      endcase
    end
    return r;
  endfunction

  // Result of one input beat. A restart clears the parse state and echoes
  // zero; while an error stands, data bytes leave the state untouched.
  function automatic hrut_result_t predict_tag(logic act, logic [7:0] octet);
    hrut_result_t t;
    role_e        r;
    logic [7:0]   c;
    r = ROLE_NONE;
    c = 8'h00;
    if (act == ActRestart) begin
      clear_state();
    end else begin
      c = octet;
      if (err == ERR_NONE) r = tag_byte(c);
    end
    t.byte_role    = r;
    t.echo_byte    = c;
    t.parse_status = (err != ERR_NONE) ? STATUS_ERROR :
                     (ph == PH_DONE) ? STATUS_DONE : STATUS_BUSY;
    t.error_code   = err;
    t.uri_kind     = kind;
    t.port_value   = 16'(port_acc);
    t.port_given   = port_seen;
    t.default_path = path_dflt;
    return t;
  endfunction

  // A hand-written result with no port and no defaulted path.
  function automatic hrut_result_t mk_tag(role_e r, logic [7:0] echo, status_e s,
                                          error_e e, kind_e k);
    hrut_result_t t;
    t = '0;
    t.byte_role    = r;
    t.echo_byte    = echo;
    t.parse_status = s;
    t.error_code   = e;
    t.uri_kind     = k;
    return t;
  endfunction

  // --------------------------------------------------------------------------
  // Directed list helpers.
  // --------------------------------------------------------------------------
  function automatic void add_row(row_op_e op, logic [12:0] value, bit typed,
                                  hrut_result_t tag);
    dir_row_t row;
    row.op    = op;
    row.value = value;
    row.typed = typed;
    row.tag   = tag;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_restart();
    add_row(ROW_RESTART, '0, 1'b1,
            mk_tag(ROLE_NONE, 8'h00, STATUS_BUSY, ERR_NONE, KIND_UNKNOWN));
  endfunction

  function automatic void add_text(string s);
    foreach (s[i]) add_row(ROW_DATA, 13'(s[i]), 1'b0, '0);
  endfunction

  // --------------------------------------------------------------------------
  // Random request builder. Most requests are well formed with random
  // content so that the parse reaches the port, path, query and fragment;
  // the rest are corrupted by one random byte, trailing bytes, or pure noise.
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pick(string pool);
    return pool[$urandom_range(0, pool.len() - 1)];
  endfunction

  function automatic void push_beat(logic act, logic [7:0] octet);
    uri_beat_t b;
    b.act   = act;
    b.octet = octet;
    uri_beats.push_back(b);
  endfunction

  function automatic void push_text(string s);
    foreach (s[i]) push_beat(ActData, s[i]);
  endfunction

  function automatic void push_run(string pool, int n);
    repeat (n) push_beat(ActData, pick(pool));
  endfunction

  // Mostly short fields, so that small capacities overflow now and then.
  function automatic int field_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 5);
  endfunction

  function automatic void push_query_frag();
    if ($urandom_range(0, 2) == 0) begin
      push_beat(ActData, ChQmark);
      push_run(UricChars, field_len());
    end
    if ($urandom_range(0, 2) == 0) begin
      push_beat(ActData, ChHash);
      push_run(UricChars, field_len());
    end
    push_beat(ActData, pick(Blanks));
  endfunction

  function automatic void push_path_tail();
    push_run(PathChars, field_len());
    push_query_frag();
  endfunction

  function automatic void build_request();
    int         form;
    int         pos;
    logic [7:0] b;
    // The restart byte is random because the block must ignore it.
    push_beat(ActRestart, 8'($urandom_range(0, 255)));
    push_run(Blanks, $urandom_range(0, 2));
    form = $urandom_range(0, 99);
    if (form < 8) begin
      push_beat(ActData, ChStar);
      push_beat(ActData, pick(Blanks));
    end else if (form < 30) begin
      push_beat(ActData, ChSlash);
      push_path_tail();
    end else if (form < 75) begin
      case ($urandom_range(0, 5))
        0, 1:    push_text("http");
        2, 3:    push_text("https");
        4:       push_text("HTTP");
        default: push_text("httpsx");
      endcase
      push_beat(ActData, ChColon);
      push_run("/", $urandom_range(0, 3));
      push_beat(ActData, pick(Alnum));
      push_run(HostChars, field_len());
      if ($urandom_range(0, 2) == 0) begin
        push_beat(ActData, ChColon);
        push_run(Digits, ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5));
      end
      if ($urandom_range(0, 3) == 0) begin
        push_query_frag();
      end else begin
        push_beat(ActData, ChSlash);
        push_path_tail();
      end
    end else if (form < 90) begin
      push_beat(ActData, pick(Letters));
      push_run(SchemeChars, field_len());
      push_beat(ActData, ChColon);
      repeat (field_len()) begin
        do b = 8'($urandom_range(0, 255)); while (is_blank(b));
        push_beat(ActData, b);
      end
      push_beat(ActData, pick(Blanks));
    end else begin
      repeat ($urandom_range(1, 8)) push_beat(ActData, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 7) == 0) push_run(PathChars, $urandom_range(1, 3));
    if ($urandom_range(0, 7) == 0) begin
      pos = $urandom_range(1, uri_beats.size() - 1);
      uri_beats[pos].octet = 8'($urandom_range(0, 255));
    end
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, GapMax);
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. A beat is accepted at the edge where valid and ready are
  // both high; the model is stepped at that edge. Valid only drops when the
  // next beat draws a gap, so it never gets two assignments in one step.
  // --------------------------------------------------------------------------
  task automatic send_beat(logic act, logic [7:0] octet, bit typed, hrut_result_t tag);
    int           gap;
    hrut_result_t want;
    gap = draw_gap();
    if (gap > 0) begin
      byte_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_in.valid  <= 1'b1;
    byte_in.action <= act;
    byte_in.octet  <= octet;
    do @(posedge clk_i); while (byte_in.ready !== 1'b1);
    want = predict_tag(act, octet);
    expected_tags.push_back(typed ? tag : want);
  endtask

  // Holds off the sender until every outstanding result beat has come back.
  // Each beat yields exactly one result, so the block is idle afterwards.
  task automatic drain_results();
    byte_in.valid <= 1'b0;
    while (expected_tags.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [12:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = value;
  endtask

  // --------------------------------------------------------------------------
  // Receiver side and checking.
  // --------------------------------------------------------------------------
  function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  function automatic void check_tag(hrut_result_t got);
    hrut_result_t want;
    if (expected_tags.size() == 0) begin
      $display("%0t: result beat with nothing expected, expected none, actual echo %0h",
               $time, got.echo_byte);
      mismatch_count++;
      return;
    end
    want = expected_tags.pop_front();
    cmp_field("byte_role", want.byte_role, got.byte_role);
    cmp_field("echo_byte", want.echo_byte, got.echo_byte);
    cmp_field("parse_status", want.parse_status, got.parse_status);
    cmp_field("error_code", want.error_code, got.error_code);
    cmp_field("uri_kind", want.uri_kind, got.uri_kind);
    cmp_field("port_value", want.port_value, got.port_value);
    cmp_field("port_given", want.port_given, got.port_given);
    cmp_field("default_path", want.default_path, got.default_path);
  endfunction

  // The receiver draws a stall before each beat and then holds ready high
  // until a beat is taken. Outputs are sampled at the edge, before the
  // block's own updates for that edge land.
  initial begin
    int           stall;
    hrut_result_t got;
    tag_out.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        tag_out.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      tag_out.ready <= 1'b1;
      do @(posedge clk_i); while (tag_out.valid !== 1'b1);
      got.byte_role    = role_e'(tag_out.byte_role);
      got.echo_byte    = tag_out.echo_byte;
      got.parse_status = status_e'(tag_out.parse_status);
      got.error_code   = error_e'(tag_out.error_code);
      got.uri_kind     = kind_e'(tag_out.uri_kind);
      got.port_value   = tag_out.port_value;
      got.port_given   = tag_out.port_given;
      got.default_path = tag_out.default_path;
      check_tag(got);
    end
  end

  // A stuck handshake ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: run timed out", $time);
    $display("[http_request_uri_tokenizer_top] ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence: reset, the directed list, then random phases, each one
  // opened by a capacity write while the block is idle.
  // --------------------------------------------------------------------------
  initial begin
    uri_beat_t b;
    int        sent;
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    byte_in.valid  <= 1'b0;
    byte_in.action <= ActData;
    byte_in.octet  <= 8'h00;
    mismatch_count = 0;
    no_idle = 1'b0;
    cap_reg = CapacityReset;
    clear_state();

    // A leading blank, the asterisk form ended by a tab, then a byte after
    // completion, which must raise the error.
    add_row(ROW_DATA, 13'(ChSp), 1'b1,
            mk_tag(ROLE_NONE, ChSp, STATUS_BUSY, ERR_NONE, KIND_UNKNOWN));
    add_row(ROW_DATA, 13'(ChStar), 1'b1,
            mk_tag(ROLE_ASTERISK, ChStar, STATUS_BUSY, ERR_NONE, KIND_UNKNOWN));
    add_row(ROW_DATA, 13'(ChHt), 1'b1,
            mk_tag(ROLE_NONE, ChHt, STATUS_DONE, ERR_NONE, KIND_ASTERISK));
    add_row(ROW_DATA, 13'h0FF, 1'b1,
            mk_tag(ROLE_NONE, 8'hFF, STATUS_ERROR, ERR_AFTER, KIND_ASTERISK));
    add_restart();
    // A zero byte cannot open a scheme.
    add_row(ROW_DATA, 13'h000, 1'b1,
            mk_tag(ROLE_NONE, 8'h00, STATUS_ERROR, ERR_SCHEME, KIND_UNKNOWN));
    add_restart();
    // The fifth port digit pushes the port past 65535.
    add_text("http:a:70000");
    add_restart();
    // A port separator with no digits before the end.
    add_text("http:/b: ");
    add_restart();
    // An unknown scheme turns its colon and the rest into opaque text.
    add_text("a: ");
    // With no room at all the first scheme byte already overflows.
    add_row(ROW_CAP, 13'd0, 1'b0, '0);
    add_restart();
    add_row(ROW_DATA, 13'("x"), 1'b1,
            mk_tag(ROLE_NONE, "x", STATUS_ERROR, ERR_OVERFLOW, KIND_UNKNOWN));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].op)
        ROW_CAP: begin
          drain_results();
          write_capacity(dir_rows[i].value);
        end
        ROW_RESTART: send_beat(ActRestart, dir_rows[i].value[7:0], dir_rows[i].typed,
                               dir_rows[i].tag);
        default:     send_beat(ActData, dir_rows[i].value[7:0], dir_rows[i].typed,
                               dir_rows[i].tag);
      endcase
    end

    // Random phases. The last one uses a random small capacity, and some
    // phases run with no idling on either side.
    for (int p = 0; p <= 10; p++) begin
      drain_results();
      write_capacity((p == 10) ? 13'($urandom_range(1, 24)) : cap_plan[p]);
      no_idle = (p % 4 == 2);
      sent = 0;
      while (sent < PhaseBeats) begin
        build_request();
        while (uri_beats.size() != 0) begin
          b = uri_beats.pop_front();
          send_beat(b.act, b.octet, 1'b0, '0);
          sent++;
        end
      end
    end
    no_idle = 1'b0;

    // Wait for the last results, then run on for DrainHold cycles so that any stray
    // beat from the block still shows up as a failure.
    drain_results();
    repeat (DrainHold) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[http_request_uri_tokenizer_top] OK");
    end else begin
      $display("[http_request_uri_tokenizer_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
